@@ hdl/evpi_pkg.sv @@
package evpi_pkg;

   // Fixed table geometry
   localparam int RATE_POINTS  = 4;
   localparam int TEMP_POINTS  = 5;
   localparam int GRID_ENTRIES = 20;
   localparam int GRID_AW      = 5;

   // Datapath widths
   localparam int MA_W   = 32;            // multiplier operand A (signed)
   localparam int MB_W   = 18;            // multiplier operand B (signed)
   localparam int PROD_W = MA_W + MB_W;
   localparam int NUM_W  = 42;            // divider numerator / quotient (signed)
   localparam int DEN_W  = 21;            // divider denominator (signed)
   localparam int WIDE_W = 43;            // accumulation width before saturation

   // Request kinds (tuser)
   localparam logic REQ_COMPUTE = 1'b0;
   localparam logic REQ_TABLE   = 1'b1;

   // Table selects
   localparam logic [2:0] TBL_RATE    = 3'd0;
   localparam logic [2:0] TBL_TEMP    = 3'd1;
   localparam logic [2:0] TBL_GRID    = 3'd2;
   localparam logic [2:0] TBL_AGE_CYC = 3'd3;
   localparam logic [2:0] TBL_AGE_RES = 3'd4;

   // Register indexes
   localparam int CSR_AW = 2;
   localparam logic [CSR_AW-1:0] CSR_CAPACITY = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_FLOOR    = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_COEF     = 2'd2;

   // Register reset values
   localparam logic [15:0] CAPACITY_RST = 16'd2000;
   localparam logic [15:0] FLOOR_RST    = 16'd3000;
   localparam logic [7:0]  COEF_RST     = 8'd10;
   localparam logic [6:0]  HEALTH_RST   = 7'd100;

   // Arithmetic constants
   localparam logic [15:0] CRATE_SCALE  = 16'd100;
   localparam logic [17:0] COMP_UNITY   = 18'd1000;
   localparam logic [16:0] FLOOR_MARGIN = 17'd30;
   localparam logic [13:0] HEALTH_FULL  = 14'd10000;
   localparam logic [15:0] OFF_LIMIT    = 16'd255;
   localparam logic [6:0]  HEALTH_MAX   = 7'd100;
   localparam logic [15:0] CYCLE_MIN    = 16'd10;
   localparam logic [DEN_W-1:0] DEN_MILLI   = 21'd1000;
   localparam logic [DEN_W-1:0] DEN_COMP    = 21'd20000;
   localparam logic [DEN_W-1:0] DEN_PERCENT = 21'd100;

   // Controller states, also the step code handed to the datapath
   typedef enum logic [5:0] {
      S_IDLE, S_MUL_C, S_DIV_C, S_RATE_C, S_SEL, S_AGE_SCAN, S_AGE_MUL, S_AGE_DIV,
      S_AGE_R, S_IR_MUL, S_IR_DIV, S_IR, S_G0, S_G1, S_G2, S_P_MUL1, S_P_MUL2,
      S_P_DIV, S_P_X, S_T_MUL, S_T_DIV, S_T_V, S_T_FL, S_C_MUL1, S_C_DIV1,
      S_C_MUL2, S_C_DIV2, S_C_V, S_H_MUL, S_H_DIV1, S_H_ADD, S_H_DIV2, S_H_SET,
      S_OUT
   } state_type;

   typedef struct packed {
      state_type step;
      logic      accept;
      logic      div_start;
      logic      out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pt_last;
      logic div_busy;
      logic div_done;
   } sts_type;

   function automatic logic [15:0] sat16(input logic signed [WIDE_W-1:0] v);
      logic [15:0] r;
      if (v < 0) r = 16'd0;
      else if (v > 43'sd65535) r = 16'hFFFF;
      else r = v[15:0];
      return r;
   endfunction

endpackage

@@ hdl/evpi_ram.sv @@
module evpi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/evpi_div.sv @@
module evpi_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [evpi_pkg::NUM_W-1:0]   num,
   input  logic signed [evpi_pkg::DEN_W-1:0]   den,
   output logic                                busy,
   output logic                                done,
   output logic signed [evpi_pkg::NUM_W-1:0]   quot
);

   import evpi_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [DEN_W:0]    trial;

   // One quotient bit per cycle, restoring, on magnitudes
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         dmag_in = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
         neg_in  = num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, dmag_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

@@ hdl/evpi_datapath.sv @@
module evpi_datapath #(
   parameter int AGING_POINTS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  evpi_pkg::cmd_type      cmd,
   output evpi_pkg::sts_type      sts,
   input  logic                   req_type,
   input  logic [14:0]            current_abs_ma,
   input  logic [7:0]             max_temperature,
   input  logic [15:0]            cycle_count,
   input  logic [15:0]            resistance_factor,
   input  logic [15:0]            cedv_average,
   input  logic [2:0]             table_select,
   input  logic [4:0]             table_index,
   input  logic [15:0]            table_value,
   input  logic                   csr_we,
   input  logic [evpi_pkg::CSR_AW-1:0] csr_addr,
   input  logic [15:0]            csr_wdata,
   output logic [15:0]            end_voltage_mv,
   output logic [15:0]            ir_drop_mv,
   output logic [6:0]             state_of_health
);

   import evpi_pkg::*;

   localparam int JW = $clog2(AGING_POINTS);
   localparam logic [JW-1:0] AGE_LAST = JW'(AGING_POINTS - 1);
   localparam logic [5:0]    AGE_CNT  = 6'(AGING_POINTS);

   // Configuration
   logic [15:0] cap_ff, cap_in, floor_ff, floor_in;
   logic [7:0]  coef_ff, coef_in;

   // Tables
   logic [15:0] rate_brk_ff [RATE_POINTS];
   logic [7:0]  temp_brk_ff [TEMP_POINTS];
   logic [15:0] age_cyc_ff  [AGING_POINTS];
   logic [7:0]  age_res_ff  [AGING_POINTS];

   // Working registers
   logic [14:0] cur_ff, cur_in;
   logic [7:0]  temp_ff, temp_in;
   logic [15:0] cyc_ff, cyc_in, res_ff, res_in, cedv_ff, cedv_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [15:0] c_ff, c_in, off_ff, off_in, span_ff, span_in;
   logic [1:0]  row;
   logic [2:0]  col;
   logic        extra_ff, extra_in;
   logic [7:0]  toff_ff, toff_in, tspan_ff, tspan_in;
   logic [GRID_AW-1:0] addr_ff, addr_in;
   logic [JW-1:0] j_ff, j_in;
   logic        scan_done_ff, scan_done_in;
   logic [15:0] prev_cyc_ff, prev_cyc_in, stop_cyc_ff, stop_cyc_in;
   logic [7:0]  prev_res_ff, prev_res_in, stop_res_ff, stop_res_in;
   logic [23:0] r_ff, r_in;
   logic [15:0] ir_ff, ir_in;
   logic        pt_ff, pt_in;
   logic [15:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [31:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [WIDE_W-1:0] vsum_ff, vsum_in;
   logic [15:0] v_ff, v_in;
   logic [22:0] hnum_ff, hnum_in;
   logic [6:0]  soh_ff, soh_in;
   logic [15:0] out_v_ff, out_v_in, out_ir_ff, out_ir_in;
   logic [6:0]  out_soh_ff, out_soh_in;

   // Shared units
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [NUM_W-1:0]  div_num, quot;
   logic signed [DEN_W-1:0]  div_den, age_span;
   logic                     div_busy, div_done;
   logic [GRID_AW-1:0]       raddr;
   logic [15:0]              rdata;
   logic                     tbl_we;
   logic [15:0]              point_base;
   logic [13:0]              health_d;
   logic [16:0]              floor_pt;
   logic [15:0]              floor_sat, v_sat;
   logic signed [WIDE_W-1:0] rsum, csum;

   assign tbl_we = cmd.accept && (req_type == REQ_TABLE);

   evpi_ram #(.WIDTH(16), .DEPTH(GRID_ENTRIES)) u_grid (
      .clock (clock),
      .we    (tbl_we && (table_select == TBL_GRID) && (table_index < 5'(GRID_ENTRIES))),
      .waddr (table_index),
      .wdata (table_value),
      .raddr (raddr),
      .rdata (rdata)
   );

   evpi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   assign age_span = $signed({5'd0, stop_cyc_ff}) - $signed({5'd0, prev_cyc_ff});
   assign mul_p    = mul_a * mul_b;
   assign point_base = extra_ff ? hi_ff : lo_ff;
   assign health_d = (ir_ff > 16'(HEALTH_FULL)) ? 14'd0 : 14'(HEALTH_FULL - ir_ff);
   assign floor_pt = {1'b0, floor_ff} + FLOOR_MARGIN;
   assign floor_sat = floor_pt[16] ? 16'hFFFF : floor_pt[15:0];
   assign v_sat = sat16(vsum_ff);

   // Table writes
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         if (table_select == TBL_RATE && table_index < 5'(RATE_POINTS)) begin
            rate_brk_ff[table_index[1:0]] <= table_value;
         end
         if (table_select == TBL_TEMP && table_index < 5'(TEMP_POINTS)) begin
            temp_brk_ff[table_index[2:0]] <= table_value[7:0];
         end
         if (table_select == TBL_AGE_CYC && {1'b0, table_index} < AGE_CNT) begin
            age_cyc_ff[table_index[JW-1:0]] <= table_value;
         end
         if (table_select == TBL_AGE_RES && {1'b0, table_index} < AGE_CNT) begin
            age_res_ff[table_index[JW-1:0]] <= table_value[7:0];
         end
      end
   end

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         S_MUL_C: begin
            mul_a = $signed({17'd0, cur_ff});
            mul_b = $signed({2'd0, CRATE_SCALE});
         end
         S_AGE_MUL: begin
            mul_a = $signed({24'd0, stop_res_ff}) - $signed({24'd0, prev_res_ff});
            mul_b = $signed({2'd0, cyc_ff}) - $signed({2'd0, prev_cyc_ff});
         end
         S_IR_MUL: begin
            mul_a = $signed({8'd0, r_ff});
            mul_b = $signed({3'd0, cur_ff});
         end
         S_P_MUL1: begin
            mul_a = $signed({16'd0, lo_ff}) - $signed({16'd0, hi_ff});
            mul_b = extra_ff ? ($signed({2'd0, off_ff}) - $signed({2'd0, span_ff}))
                             : $signed({2'd0, off_ff});
         end
         S_P_MUL2: begin
            mul_a = $signed(prod_ff[MA_W-1:0]);
            mul_b = $signed({10'd0, coef_ff});
         end
         S_T_MUL: begin
            mul_a = x2_ff - x1_ff;
            mul_b = $signed({10'd0, toff_ff});
         end
         S_C_MUL1: begin
            mul_a = $signed({16'd0, res_ff});
            mul_b = $signed({2'd0, cedv_ff}) - $signed(COMP_UNITY);
         end
         S_C_MUL2: begin
            mul_a = $signed(quot[MA_W-1:0]);
            mul_b = $signed({3'd0, cur_ff});
         end
         S_H_MUL: begin
            mul_a = $signed({16'd0, cap_ff});
            mul_b = $signed({4'd0, health_d});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider operand select
   always_comb begin
      div_num = $signed(prod_ff[NUM_W-1:0]);
      div_den = $signed(DEN_MILLI);
      case (cmd.step)
         S_DIV_C:   div_den = $signed({5'd0, cap_ff});
         S_AGE_DIV: div_den = age_span;
         S_P_DIV:   div_den = extra_ff ? $signed({1'b0, {1'b0, span_ff, 3'd0} + {3'd0, span_ff, 1'b0}})
                                       : $signed({5'd0, span_ff});
         S_T_DIV:   div_den = $signed({13'd0, tspan_ff});
         S_C_DIV2:  div_den = $signed(DEN_COMP);
         S_H_DIV1:  div_den = $signed(DEN_PERCENT);
         S_H_DIV2: begin
            div_num = $signed({19'd0, hnum_ff});
            div_den = $signed({5'd0, cap_ff});
         end
         default:   div_den = $signed(DEN_MILLI);
      endcase
   end

   // Grid read address: low row entry, then the row one C-rate up
   always_comb begin
      if (cmd.step == S_G1) raddr = addr_ff + GRID_AW'(pt_ff) + GRID_AW'(TEMP_POINTS);
      else                  raddr = addr_ff + GRID_AW'(pt_ff);
   end

   // Breakpoint search for C-rate row and temperature column
   always_comb begin
      if (c_ff <= rate_brk_ff[1]) begin
         row     = 2'd0;
         off_in  = (c_ff <= rate_brk_ff[0]) ? 16'd0 : 16'(c_ff - rate_brk_ff[0]);
         span_in = 16'(rate_brk_ff[1] - rate_brk_ff[0]);
      end else if (c_ff <= rate_brk_ff[2]) begin
         row     = 2'd1;
         off_in  = 16'(c_ff - rate_brk_ff[1]);
         span_in = 16'(rate_brk_ff[2] - rate_brk_ff[1]);
      end else begin
         row     = 2'd2;
         off_in  = (16'(c_ff - rate_brk_ff[2]) > OFF_LIMIT) ? OFF_LIMIT
                                                             : 16'(c_ff - rate_brk_ff[2]);
         span_in = 16'(rate_brk_ff[3] - rate_brk_ff[2]);
      end
      extra_in = (row == 2'd2) && (off_in > span_in);

      if (temp_ff >= temp_brk_ff[1]) begin
         if (temp_ff >= temp_brk_ff[2]) begin
            if (temp_ff >= temp_brk_ff[3]) begin
               col      = 3'd3;
               tspan_in = 8'(temp_brk_ff[4] - temp_brk_ff[3]);
               toff_in  = (temp_ff >= temp_brk_ff[4]) ? tspan_in : 8'(temp_ff - temp_brk_ff[3]);
            end else begin
               col      = 3'd2;
               tspan_in = 8'(temp_brk_ff[3] - temp_brk_ff[2]);
               toff_in  = 8'(temp_ff - temp_brk_ff[2]);
            end
         end else begin
            col      = 3'd1;
            tspan_in = 8'(temp_brk_ff[2] - temp_brk_ff[1]);
            toff_in  = 8'(temp_ff - temp_brk_ff[1]);
         end
      end else begin
         col      = 3'd0;
         tspan_in = 8'(temp_brk_ff[1] - temp_brk_ff[0]);
         toff_in  = (temp_ff <= temp_brk_ff[0]) ? 8'd0 : 8'(temp_ff - temp_brk_ff[0]);
      end
      addr_in = GRID_AW'(row) * GRID_AW'(TEMP_POINTS) + GRID_AW'(col);
   end

   assign rsum = WIDE_W'($signed({1'b0, prev_res_ff}))
               + ((age_span != 0) ? WIDE_W'(quot) : WIDE_W'(0));
   assign csum = WIDE_W'($signed({1'b0, v_ff})) - WIDE_W'(quot);

   // Step execution
   always_comb begin
      cap_in = cap_ff;   floor_in = floor_ff;   coef_in = coef_ff;
      cur_in = cur_ff;   temp_in = temp_ff;     cyc_in = cyc_ff;
      res_in = res_ff;   cedv_in = cedv_ff;     prod_in = prod_ff;
      c_in = c_ff;       j_in = j_ff;           scan_done_in = scan_done_ff;
      prev_cyc_in = prev_cyc_ff;  prev_res_in = prev_res_ff;
      stop_cyc_in = stop_cyc_ff;  stop_res_in = stop_res_ff;
      r_in = r_ff;       ir_in = ir_ff;         pt_in = pt_ff;
      lo_in = lo_ff;     hi_in = hi_ff;         x1_in = x1_ff;   x2_in = x2_ff;
      vsum_in = vsum_ff; v_in = v_ff;           hnum_in = hnum_ff;
      soh_in = soh_ff;
      out_v_in = out_v_ff;  out_ir_in = out_ir_ff;  out_soh_in = out_soh_ff;

      // configuration writes
      if (csr_we) begin
         if (csr_addr == CSR_CAPACITY) cap_in = csr_wdata;
         if (csr_addr == CSR_FLOOR)    floor_in = csr_wdata;
         if (csr_addr == CSR_COEF)     coef_in = csr_wdata[7:0];
      end

      if (cmd.accept) begin
         cur_in  = current_abs_ma;
         temp_in = max_temperature;
         cyc_in  = cycle_count;
         res_in  = resistance_factor;
         cedv_in = cedv_average;
      end

      case (cmd.step)
         S_MUL_C, S_AGE_MUL, S_IR_MUL, S_P_MUL1, S_T_MUL, S_C_MUL1, S_C_MUL2,
         S_H_MUL: prod_in = mul_p;
         S_P_MUL2: if (extra_ff) prod_in = mul_p;
         S_RATE_C: begin
            if (cap_ff == 16'd0 || quot > 42'sd65535) c_in = 16'hFFFF;
            else                                      c_in = quot[15:0];
         end
         S_SEL: begin
            j_in = '0;
            scan_done_in = 1'b0;
            prev_cyc_in = '0;
            prev_res_in = '0;
            pt_in = 1'b0;
         end
         S_AGE_SCAN: begin
            if (!scan_done_ff) begin
               if (j_ff == AGE_LAST || cyc_ff < age_cyc_ff[j_ff]) begin
                  stop_cyc_in  = age_cyc_ff[j_ff];
                  stop_res_in  = age_res_ff[j_ff];
                  scan_done_in = 1'b1;
               end else begin
                  prev_cyc_in = age_cyc_ff[j_ff];
                  prev_res_in = age_res_ff[j_ff];
                  j_in = JW'(j_ff + 1'b1);
               end
            end
         end
         S_AGE_R: r_in = (rsum < 0) ? 24'd0 : rsum[23:0];
         S_IR: ir_in = (quot > 42'sd65535) ? 16'hFFFF : quot[15:0];
         S_G1: lo_in = rdata;
         S_G2: hi_in = rdata;
         S_P_X: begin
            if (span_ff == 16'd0) begin
               if (pt_ff) x2_in = $signed({16'd0, point_base});
               else       x1_in = $signed({16'd0, point_base});
            end else begin
               if (pt_ff) x2_in = 32'($signed({1'b0, point_base}) - quot);
               else       x1_in = 32'($signed({1'b0, point_base}) - quot);
            end
            pt_in = 1'b1;
         end
         S_T_V: begin
            vsum_in = WIDE_W'(x1_ff)
                    + ((tspan_ff != 8'd0) ? WIDE_W'(quot) : WIDE_W'(0))
                    - WIDE_W'($signed({1'b0, ir_ff}));
         end
         S_T_FL: v_in = (v_sat <= floor_sat) ? floor_sat : v_sat;
         S_C_V: v_in = sat16(csum);
         S_H_ADD: hnum_in = quot[22:0] + {8'd0, cap_ff[15:1]};
         S_H_SET: begin
            if (cyc_ff > CYCLE_MIN && cap_ff != 16'd0) begin
               soh_in = (quot >= 42'sd100) ? HEALTH_MAX : quot[6:0];
            end
         end
         default: ;
      endcase

      if (cmd.out_load) begin
         out_v_in   = v_ff;
         out_ir_in  = ir_ff;
         out_soh_in = soh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAPACITY_RST;
         floor_ff <= FLOOR_RST;
         coef_ff  <= COEF_RST;
         soh_ff   <= HEALTH_RST;
         scan_done_ff <= 1'b0;
         pt_ff    <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         floor_ff <= floor_in;
         coef_ff  <= coef_in;
         soh_ff   <= soh_in;
         scan_done_ff <= scan_done_in;
         pt_ff    <= pt_in;
      end
      cur_ff <= cur_in;   temp_ff <= temp_in;   cyc_ff <= cyc_in;
      res_ff <= res_in;   cedv_ff <= cedv_in;   prod_ff <= prod_in;
      c_ff <= c_in;
      if (cmd.step == S_SEL) begin
         off_ff   <= off_in;
         span_ff  <= span_in;
         extra_ff <= extra_in;
         toff_ff  <= toff_in;
         tspan_ff <= tspan_in;
         addr_ff  <= addr_in;
      end
      j_ff <= j_in;
      prev_cyc_ff <= prev_cyc_in;  prev_res_ff <= prev_res_in;
      stop_cyc_ff <= stop_cyc_in;  stop_res_ff <= stop_res_in;
      r_ff <= r_in;   ir_ff <= ir_in;
      lo_ff <= lo_in; hi_ff <= hi_in; x1_ff <= x1_in; x2_ff <= x2_in;
      vsum_ff <= vsum_in;  v_ff <= v_in;  hnum_ff <= hnum_in;
      out_v_ff <= out_v_in;  out_ir_ff <= out_ir_in;  out_soh_ff <= out_soh_in;
   end

   assign sts.scan_done = scan_done_ff;
   assign sts.pt_last   = pt_ff;
   assign sts.div_busy  = div_busy;
   assign sts.div_done  = div_done;

   assign end_voltage_mv  = out_v_ff;
   assign ir_drop_mv      = out_ir_ff;
   assign state_of_health = out_soh_ff;

endmodule

@@ hdl/evpi_ctrl.sv @@
module evpi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_type,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  evpi_pkg::sts_type sts,
   output evpi_pkg::cmd_type cmd
);

   import evpi_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      div_run_ff, div_run_in;
   logic      is_div;

   assign is_div = (state_ff == S_DIV_C) || (state_ff == S_AGE_DIV) || (state_ff == S_IR_DIV)
                || (state_ff == S_P_DIV) || (state_ff == S_T_DIV) || (state_ff == S_C_DIV1)
                || (state_ff == S_C_DIV2) || (state_ff == S_H_DIV1) || (state_ff == S_H_DIV2);

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.step      = state_ff;
      cmd.accept    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.out_load  = 1'b0;
      req_tready    = 1'b0;
      div_run_in    = div_run_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      // divide steps: kick the divider once, move on when it finishes
      if (is_div) begin
         cmd.div_start = !div_run_ff;
         if (!div_run_ff) div_run_in = 1'b1;
         if (sts.div_done) div_run_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_type == REQ_COMPUTE) state_in = S_MUL_C;
            end
         end
         S_MUL_C:    state_in = S_DIV_C;
         S_DIV_C:    if (sts.div_done) state_in = S_RATE_C;
         S_RATE_C:   state_in = S_SEL;
         S_SEL:      state_in = S_AGE_SCAN;
         S_AGE_SCAN: if (sts.scan_done) state_in = S_AGE_MUL;
         S_AGE_MUL:  state_in = S_AGE_DIV;
         S_AGE_DIV:  if (sts.div_done) state_in = S_AGE_R;
         S_AGE_R:    state_in = S_IR_MUL;
         S_IR_MUL:   state_in = S_IR_DIV;
         S_IR_DIV:   if (sts.div_done) state_in = S_IR;
         S_IR:       state_in = S_G0;
         S_G0:       state_in = S_G1;
         S_G1:       state_in = S_G2;
         S_G2:       state_in = S_P_MUL1;
         S_P_MUL1:   state_in = S_P_MUL2;
         S_P_MUL2:   state_in = S_P_DIV;
         S_P_DIV:    if (sts.div_done) state_in = S_P_X;
         S_P_X:      state_in = sts.pt_last ? S_T_MUL : S_G0;
         S_T_MUL:    state_in = S_T_DIV;
         S_T_DIV:    if (sts.div_done) state_in = S_T_V;
         S_T_V:      state_in = S_T_FL;
         S_T_FL:     state_in = S_C_MUL1;
         S_C_MUL1:   state_in = S_C_DIV1;
         S_C_DIV1:   if (sts.div_done) state_in = S_C_MUL2;
         S_C_MUL2:   state_in = S_C_DIV2;
         S_C_DIV2:   if (sts.div_done) state_in = S_C_V;
         S_C_V:      state_in = S_H_MUL;
         S_H_MUL:    state_in = S_H_DIV1;
         S_H_DIV1:   if (sts.div_done) state_in = S_H_ADD;
         S_H_ADD:    state_in = S_H_DIV2;
         S_H_DIV2:   if (sts.div_done) state_in = S_H_SET;
         S_H_SET:    state_in = S_OUT;
         S_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_run_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_run_ff   <= div_run_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Divider is only started when idle
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   // A quotient only arrives while a divide step waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> is_div)
      else $error("quotient outside a divide step");

   // A result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   // A compute transfer closes the input until its result is queued
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_type == REQ_COMPUTE) |=> !req_tready)
      else $error("input open during computation");

endmodule

@@ hdl/end_voltage_point_interpolator.sv @@
// Compensated end-of-discharge voltage point for a battery gauge. A request
// with tuser high writes one table entry (C-rate breakpoints, temperature
// breakpoints, the 4x5 voltage grid or the aging table) and returns nothing.
// A request with tuser low computes one result: C-rate, bilinear grid
// interpolation with extrapolation above the last C-rate, IR drop from the
// aging table, floor at voltage_floor + 30 mV, resistance compensation and
// the held state of health. A compute runs ten quotients one after another
// through one shared serial divider (start, 42 quotient bits, finish), plus
// the other steps and an aging table scan whose length is set by how far
// the cycle count reaches into the table. The input reopens the cycle after
// the result is queued. The next request is taken while a finished result
// still waits on the output; a second compute then stalls at the output
// until the first is taken. The user must write configuration through csr_*
// only while the block is idle; the block itself does not enforce this.
module end_voltage_point_interpolator #(
   parameter int AGING_POINTS = 6
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: current_abs_ma[14:0], max_temperature[22:15], cycle_count[38:23],
   //        resistance_factor[54:39], cedv_average[70:55], table_select[73:71],
   //        table_index[78:74], table_value[94:79], zero [95]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        req_tuser,      // req_type
   // tdata: end_voltage_mv[15:0], ir_drop_mv[31:16], state_of_health[38:32], zero [39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [evpi_pkg::CSR_AW-1:0] csr_addr,
   input  logic [15:0] csr_wdata
);

   import evpi_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] end_voltage_mv, ir_drop_mv;
   logic [6:0]  state_of_health;

   evpi_datapath #(.AGING_POINTS(AGING_POINTS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_tuser),
      .current_abs_ma    (req_tdata[14:0]),
      .max_temperature   (req_tdata[22:15]),
      .cycle_count       (req_tdata[38:23]),
      .resistance_factor (req_tdata[54:39]),
      .cedv_average      (req_tdata[70:55]),
      .table_select      (req_tdata[73:71]),
      .table_index       (req_tdata[78:74]),
      .table_value       (req_tdata[94:79]),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .end_voltage_mv    (end_voltage_mv),
      .ir_drop_mv        (ir_drop_mv),
      .state_of_health   (state_of_health)
   );

   evpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   assign rsp_tdata = {1'b0, state_of_health, ir_drop_mv, end_voltage_mv};

endmodule
